@@ src/arc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP resolver cache package
// Shared types and constants for the resolver cell chain and its sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arc_pkg;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned AGE_W  = 17;
  localparam int unsigned MS_W   = 16;

  // Most results one flush may produce.
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned RES_CNT_W    = 5;

  localparam logic [MS_W-1:0]  HOLD_RESET = 16'd5000;
  localparam logic [MS_W-1:0]  LIFE_RESET = 16'd30000;
  localparam logic [MAC_W-1:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

  // Input item actions.
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_RECV = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Frame types and ARP opcodes.
  localparam logic [1:0] FT_IPV4    = 2'd0;
  localparam logic [1:0] FT_ARP     = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;
  localparam logic [1:0] REG_LIFE    = 2'd3;

  typedef enum logic [2:0] {
    KIND_IPV4    = 3'd0,
    KIND_ARP_REQ = 3'd1,
    KIND_ARP_REP = 3'd2,
    KIND_UP      = 3'd3,
    KIND_DROP    = 3'd4
  } arc_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_POST,
    ST_FLUSH
  } arc_state_e;

  // Broadcast control shared by every entry cell of one table.
  typedef struct packed {
    logic              tick;
    logic [MS_W-1:0]   elapsed;
    logic [MS_W-1:0]   limit;
    logic [IP_W-1:0]   key;
    logic [MAC_W-1:0]  wdata;
  } arc_cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/arc_entry.sv @@
// ----------------------------------------------------------------------------
// ARP resolver table entry cell
// One mapping or request entry: compares the lookup key, ages on ticks and
// expires itself once its age passes the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arc_entry (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire arc_pkg::arc_cell_ctrl_t      ctrl_i,
  input  wire logic                         we_i,
  output logic                              valid_o,
  output logic [arc_pkg::AGE_W-1:0]         age_o,
  output logic [arc_pkg::MAC_W-1:0]         data_o,
  output logic                              match_o
);

  logic                       valid_q, valid_d;
  logic [arc_pkg::AGE_W-1:0]  age_q, age_d;
  logic [arc_pkg::IP_W-1:0]   ip_q;
  logic [arc_pkg::MAC_W-1:0]  data_q;
  logic [arc_pkg::AGE_W:0]    sum;
  logic [arc_pkg::AGE_W-1:0]  sat;

  // Saturating age update and expiry test.
  always_comb begin
    sum     = {1'b0, age_q} + {{(arc_pkg::AGE_W + 1 - arc_pkg::MS_W){1'b0}}, ctrl_i.elapsed};
    sat     = sum[arc_pkg::AGE_W] ? {arc_pkg::AGE_W{1'b1}} : sum[arc_pkg::AGE_W-1:0];
    valid_d = valid_q;
    age_d   = age_q;
    if (we_i) begin
      valid_d = 1'b1;
      age_d   = '0;
    end else if (ctrl_i.tick && valid_q) begin
      if (sat > {1'b0, ctrl_i.limit}) begin
        valid_d = 1'b0;
        age_d   = '0;
      end else begin
        age_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  // Address and data are only read behind the valid bit.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ip_q   <= ctrl_i.key;
      data_q <= ctrl_i.wdata;
    end
  end

  assign valid_o = valid_q;
  assign age_o   = age_q;
  assign data_o  = data_q;
  assign match_o = valid_q && (ip_q == ctrl_i.key);

endmodule

`default_nettype wire

@@ src/arc_pend_cell.sv @@
// ----------------------------------------------------------------------------
// ARP resolver pending datagram cell
// One slot of the parked-datagram queue; shifts toward the head or loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arc_pend_cell #(
  parameter int unsigned TW = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       shift_i,
  input  wire logic                       load_i,
  input  wire logic [arc_pkg::IP_W-1:0]   nb_ip_i,
  input  wire logic [TW-1:0]              nb_tag_i,
  input  wire logic [arc_pkg::IP_W-1:0]   ld_ip_i,
  input  wire logic [TW-1:0]              ld_tag_i,
  output logic [arc_pkg::IP_W-1:0]        ip_o,
  output logic [TW-1:0]                   tag_o
);

  logic [arc_pkg::IP_W-1:0] ip_q;
  logic [TW-1:0]            tag_q;

  // A load wins over the shift from the neighbor above.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ip_q  <= ld_ip_i;
      tag_q <= ld_tag_i;
    end else if (shift_i) begin
      ip_q  <= nb_ip_i;
      tag_q <= nb_tag_i;
    end
  end

  assign ip_o  = ip_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

@@ src/arp_resolver_cache_unit.sv @@
// ----------------------------------------------------------------------------
// ARP resolver cache unit
// Mapping cache, request hold-off table and parked datagram queue with a
// sequencer that resolves sends, learns from ARP frames and flushes replies.
// ----------------------------------------------------------------------------
// Sequence: a tick or a send that hits the cache is resolved in the decode
// state; a table insertion that must pick a slot first scans the ages of every
// entry of that table; a reply flush steps through each parked datagram in turn.
// Throughput: one item at a time; busy stays high until its last result.
// Each result is shown for one cycle on out_valid_o; the receiver cannot stall.
// Reset clears all valid bits, ages and the queue fill count, and returns the
// registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module arp_resolver_cache_unit #(
  parameter int unsigned CACHE_ENTRIES   = 16,
  parameter int unsigned REQUEST_ENTRIES = 16,
  parameter int unsigned PENDING_ENTRIES = 16,
  parameter int unsigned TAG_BITS        = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [47:0]          cfg_data_i,
  input  wire logic [1:0]           action_i,
  input  wire logic [31:0]          next_hop_ip_i,
  input  wire logic [TAG_BITS-1:0]  datagram_tag_i,
  input  wire logic [47:0]          frame_dst_mac_i,
  input  wire logic [1:0]           frame_type_i,
  input  wire logic                 payload_ok_i,
  input  wire logic [1:0]           arp_opcode_i,
  input  wire logic [31:0]          sender_ip_i,
  input  wire logic [47:0]          sender_mac_i,
  input  wire logic [31:0]          target_ip_i,
  input  wire logic [15:0]          elapsed_ms_i,
  output logic                      out_valid_o,
  output logic [2:0]                out_kind_o,
  output logic [47:0]               dst_mac_o,
  output logic [31:0]               arp_target_ip_o,
  output logic [47:0]               arp_target_mac_o,
  output logic [TAG_BITS-1:0]       out_tag_o,
  output logic                      last_o
);

  localparam int unsigned CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned RIW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int unsigned SW  = (CIW > RIW) ? CIW : RIW;
  localparam int unsigned PCW = $clog2(PENDING_ENTRIES + 1);

  // Configuration registers.
  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [15:0] hold_q;
  logic [15:0] life_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
      hold_q    <= arc_pkg::HOLD_RESET;
      life_q    <= arc_pkg::LIFE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        arc_pkg::REG_OWN_MAC: own_mac_q <= cfg_data_i;
        arc_pkg::REG_OWN_IP:  own_ip_q  <= cfg_data_i[31:0];
        arc_pkg::REG_HOLD:    hold_q    <= cfg_data_i[15:0];
        arc_pkg::REG_LIFE:    life_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic [1:0]          act_q;
  logic [31:0]         key_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [47:0]         fdst_q;
  logic [1:0]          ftype_q;
  logic                ok_q;
  logic [1:0]          op_q;
  logic [47:0]         smac_q;
  logic [31:0]         tip_q;
  logic [15:0]         elapsed_q;

  arc_pkg::arc_state_e state_q, state_d;
  logic accept;

  assign busy   = (state_q != arc_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q     <= action_i;
      key_q     <= (action_i == arc_pkg::ACT_SEND) ? next_hop_ip_i : sender_ip_i;
      tag_q     <= datagram_tag_i;
      fdst_q    <= frame_dst_mac_i;
      ftype_q   <= frame_type_i;
      ok_q      <= payload_ok_i;
      op_q      <= arp_opcode_i;
      smac_q    <= sender_mac_i;
      tip_q     <= target_ip_i;
      elapsed_q <= elapsed_ms_i;
    end
  end

  // Control signals from the sequencer.
  logic tick_en, learn_we, scan_init, scan_we, push, fl_init, fl_step, fl_keep;
  logic tbl_d, tbl_q;

  // Mapping cache and request table cells.
  arc_pkg::arc_cell_ctrl_t c_ctrl, r_ctrl;
  logic                      c_valid [CACHE_ENTRIES];
  logic [arc_pkg::AGE_W-1:0] c_age   [CACHE_ENTRIES];
  logic [47:0]               c_mac   [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0]  c_match;
  logic [CACHE_ENTRIES-1:0]  c_we;
  logic                      r_valid [REQUEST_ENTRIES];
  logic [arc_pkg::AGE_W-1:0] r_age   [REQUEST_ENTRIES];
  logic [REQUEST_ENTRIES-1:0] r_match;
  logic [REQUEST_ENTRIES-1:0] r_we;
  logic [SW-1:0] best_d;

  assign c_ctrl = '{tick: tick_en, elapsed: elapsed_q, limit: life_q, key: key_q,
                    wdata: smac_q};
  assign r_ctrl = '{tick: tick_en, elapsed: elapsed_q, limit: hold_q, key: key_q,
                    wdata: '0};

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cache
    assign c_we[i] = (learn_we && c_match[i]) ||
                     (scan_we && !tbl_q && (best_d == SW'(i)));
    arc_entry u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (c_ctrl),
      .we_i    (c_we[i]),
      .valid_o (c_valid[i]),
      .age_o   (c_age[i]),
      .data_o  (c_mac[i]),
      .match_o (c_match[i])
    );
  end

  for (genvar i = 0; i < REQUEST_ENTRIES; i++) begin : g_req
    assign r_we[i] = scan_we && tbl_q && (best_d == SW'(i));
    arc_entry u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (r_ctrl),
      .we_i    (r_we[i]),
      .valid_o (r_valid[i]),
      .age_o   (r_age[i]),
      .data_o  (),
      .match_o (r_match[i])
    );
  end

  // Cached MAC of the matching entry; at most one entry matches a key.
  logic [47:0] hit_mac;
  logic        hit, held;

  always_comb begin
    hit_mac = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (c_match[i]) hit_mac = hit_mac | c_mac[i];
    end
  end

  assign hit  = |c_match;
  assign held = |r_match;

  // Slot selection scan: first free entry, else the oldest, lowest on a tie.
  logic [SW-1:0]             scan_q;
  logic [SW-1:0]             best_q;
  logic [arc_pkg::AGE_W-1:0] bage_q, bage_d;
  logic                      free_q, free_d;
  logic                      sc_valid, scan_last;
  logic [arc_pkg::AGE_W-1:0] sc_age;

  always_comb begin
    sc_valid  = tbl_q ? r_valid[scan_q[RIW-1:0]] : c_valid[scan_q[CIW-1:0]];
    sc_age    = tbl_q ? r_age[scan_q[RIW-1:0]]   : c_age[scan_q[CIW-1:0]];
    scan_last = (scan_q == (tbl_q ? SW'(REQUEST_ENTRIES - 1) : SW'(CACHE_ENTRIES - 1)));
    free_d    = free_q;
    best_d    = best_q;
    bage_d    = bage_q;
    if (!free_q) begin
      if (!sc_valid) begin
        free_d = 1'b1;
        best_d = scan_q;
      end else if ((scan_q == '0) || (sc_age > bage_q)) begin
        best_d = scan_q;
        bage_d = sc_age;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      free_q <= 1'b0;
      tbl_q  <= 1'b0;
    end else if (scan_init) begin
      scan_q <= '0;
      free_q <= 1'b0;
      tbl_q  <= tbl_d;
    end else if (state_q == arc_pkg::ST_SCAN) begin
      scan_q <= scan_q + SW'(1);
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bage_q <= bage_d;
  end

  // Parked datagram queue: a chain of cells packed at the low slots.
  logic [31:0]          p_ip  [PENDING_ENTRIES];
  logic [TAG_BITS-1:0]  p_tag [PENDING_ENTRIES];
  logic [PCW-1:0]       cnt_q;
  logic                 full;

  assign full = (cnt_q == PCW'(PENDING_ENTRIES));

  for (genvar i = 0; i < PENDING_ENTRIES; i++) begin : g_pend
    logic [31:0]         nb_ip;
    logic [TAG_BITS-1:0] nb_tag;
    logic                ld;
    if (i < PENDING_ENTRIES - 1) begin : g_mid
      assign nb_ip  = p_ip[i+1];
      assign nb_tag = p_tag[i+1];
    end else begin : g_end
      assign nb_ip  = '0;
      assign nb_tag = '0;
    end
    assign ld = (push && (cnt_q == PCW'(i))) ||
                (fl_keep && (cnt_q == PCW'(i + 1)));
    arc_pend_cell #(.TW(TAG_BITS)) u_cell (
      .clk_i    (clk_i),
      .shift_i  (fl_step),
      .load_i   (ld),
      .nb_ip_i  (nb_ip),
      .nb_tag_i (nb_tag),
      .ld_ip_i  (fl_step ? p_ip[0] : key_q),
      .ld_tag_i (fl_step ? p_tag[0] : tag_q),
      .ip_o     (p_ip[i]),
      .tag_o    (p_tag[i])
    );
  end

  // Flush bookkeeping; the last match is held back to mark the final result.
  logic [PCW-1:0]                left_q;
  logic [arc_pkg::RES_CNT_W-1:0] nres_q;
  logic [TAG_BITS-1:0]           hold_tag_q;
  logic                          hold_v_q;
  logic                          fl_match;

  assign fl_match = (p_ip[0] == key_q) && (nres_q < arc_pkg::RES_CNT_W'(arc_pkg::RESULT_LIMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      left_q   <= '0;
      nres_q   <= '0;
      hold_v_q <= 1'b0;
    end else if (push) begin
      cnt_q <= cnt_q + PCW'(1);
    end else if (fl_init) begin
      left_q   <= cnt_q;
      nres_q   <= '0;
      hold_v_q <= 1'b0;
    end else if (fl_step) begin
      left_q <= left_q - PCW'(1);
      if (!fl_keep) begin
        cnt_q    <= cnt_q - PCW'(1);
        nres_q   <= nres_q + arc_pkg::RES_CNT_W'(1);
        hold_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fl_step && !fl_keep) hold_tag_q <= p_tag[0];
  end

  // Sequencer: next state, table controls and the result to register.
  logic                e_valid, e_last;
  arc_pkg::arc_kind_e  e_kind;
  logic [47:0]         e_dst, e_tmac;
  logic [31:0]         e_tip;
  logic [TAG_BITS-1:0] e_tag;
  logic                for_us;

  assign for_us = (fdst_q == arc_pkg::MAC_BCAST) || (fdst_q == own_mac_q);

  always_comb begin
    state_d   = state_q;
    tick_en   = 1'b0;
    learn_we  = 1'b0;
    scan_init = 1'b0;
    scan_we   = 1'b0;
    tbl_d     = 1'b0;
    push      = 1'b0;
    fl_init   = 1'b0;
    fl_step   = 1'b0;
    fl_keep   = 1'b0;
    e_valid   = 1'b0;
    e_last    = 1'b0;
    e_kind    = arc_pkg::KIND_IPV4;
    e_dst     = '0;
    e_tip     = '0;
    e_tmac    = '0;
    e_tag     = '0;
    case (state_q)
      arc_pkg::ST_IDLE: begin
        if (accept) state_d = arc_pkg::ST_DECODE;
      end
      arc_pkg::ST_DECODE: begin
        state_d = arc_pkg::ST_IDLE;
        case (act_q)
          arc_pkg::ACT_SEND: begin
            if (hit) begin
              e_valid = 1'b1;
              e_last  = 1'b1;
              e_kind  = arc_pkg::KIND_IPV4;
              e_dst   = hit_mac;
              e_tag   = tag_q;
            end else begin
              if (full) begin
                e_valid = 1'b1;
                e_last  = held;
                e_kind  = arc_pkg::KIND_DROP;
                e_tag   = tag_q;
              end else begin
                push = 1'b1;
              end
              if (!held) begin
                scan_init = 1'b1;
                tbl_d     = 1'b1;
                state_d   = arc_pkg::ST_SCAN;
              end
            end
          end
          arc_pkg::ACT_RECV: begin
            if (for_us && ok_q) begin
              if (ftype_q == arc_pkg::FT_IPV4) begin
                e_valid = 1'b1;
                e_last  = 1'b1;
                e_kind  = arc_pkg::KIND_UP;
              end else if (ftype_q == arc_pkg::FT_ARP) begin
                if (hit) begin
                  learn_we = 1'b1;
                  state_d  = arc_pkg::ST_POST;
                end else begin
                  scan_init = 1'b1;
                  state_d   = arc_pkg::ST_SCAN;
                end
              end
            end
          end
          arc_pkg::ACT_TICK: begin
            tick_en = 1'b1;
          end
          default: ;
        endcase
      end
      arc_pkg::ST_SCAN: begin
        if (scan_last) begin
          scan_we = 1'b1;
          if (tbl_q) begin
            e_valid = 1'b1;
            e_last  = 1'b1;
            e_kind  = arc_pkg::KIND_ARP_REQ;
            e_dst   = arc_pkg::MAC_BCAST;
            e_tip   = key_q;
            state_d = arc_pkg::ST_IDLE;
          end else begin
            state_d = arc_pkg::ST_POST;
          end
        end
      end
      arc_pkg::ST_POST: begin
        state_d = arc_pkg::ST_IDLE;
        if ((op_q == arc_pkg::OP_REQUEST) && (tip_q == own_ip_q)) begin
          e_valid = 1'b1;
          e_last  = 1'b1;
          e_kind  = arc_pkg::KIND_ARP_REP;
          e_dst   = smac_q;
          e_tip   = key_q;
          e_tmac  = smac_q;
        end else if (op_q == arc_pkg::OP_REPLY) begin
          fl_init = 1'b1;
          state_d = arc_pkg::ST_FLUSH;
        end
      end
      arc_pkg::ST_FLUSH: begin
        if (left_q == '0) begin
          e_valid = hold_v_q;
          e_last  = 1'b1;
          e_dst   = smac_q;
          e_tag   = hold_tag_q;
          state_d = arc_pkg::ST_IDLE;
        end else begin
          fl_step = 1'b1;
          fl_keep = !fl_match;
          if (fl_match && hold_v_q) begin
            e_valid = 1'b1;
            e_dst   = smac_q;
            e_tag   = hold_tag_q;
          end
        end
      end
      default: state_d = arc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arc_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= e_valid;
    end
  end

  // Result register: each result transfers in the cycle after it is formed.
  always_ff @(posedge clk_i) begin
    out_kind_o       <= e_kind;
    dst_mac_o        <= e_dst;
    arp_target_ip_o  <= e_tip;
    arp_target_mac_o <= e_tmac;
    out_tag_o        <= e_tag;
    last_o           <= e_last;
  end

`ifndef NO_ASSERTIONS
  // The queue fill count never passes the number of cells.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PCW'(PENDING_ENTRIES))
    else $error("pending count out of range");

  // A flush never emits more results than the limit allows.
  a_flush_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= arc_pkg::RES_CNT_W'(arc_pkg::RESULT_LIMIT))
    else $error("flush result count above limit");

  // A learned mapping is never duplicated in the cache.
  a_cache_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(c_match))
    else $error("duplicate cache mapping");

  // The last result of an item is followed by idle, never by more results.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !busy || (state_q == arc_pkg::ST_DECODE))
    else $error("results continue after the last one");
`endif

endmodule

`default_nettype wire
